FILE: src/lmd_pkg.sv
// Shared types and constants of the 3x3 local maximum detector.
// No dependencies; imported by every module of the block but lmd_line_ram.
package lmd_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int DEF_WIDTH     = 640;
  localparam int DEF_HEIGHT    = 480;
  localparam int DEF_THRESHOLD = 0;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int THR_W       = 8;
  localparam int POS_W       = 10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_THRESHOLD    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_type_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel_value;
  } lmd_in_t;

  typedef struct packed {
    logic             is_max;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             frame_end;
  } lmd_out_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } lmd_bound_t;

endpackage

FILE: src/local_maximum_3x3_detector.sv
// Top level of the 3x3 local maximum detector (non-maximum suppression).
// Depends on lmd_pkg, lmd_line_ram and lmd_window.
//
// Takes one raster pixel or flush transaction per clock when not stalled and
// gives at most one result per transaction; a result passes through stages a
// and w into the output register after the transaction that releases it.
// The result for a pixel is released by the pixel one row and one column
// later, so the last width+1 results of a frame (all of them on a one-row
// frame) wait for flush transactions, one result per flush. Pixels sent while
// results wait for flushes are dropped. On a one-row frame the input stalls
// after the last pixel while the window takes an extra column. Two line RAMs
// of MAX_WIDTH entries, one read and one write each per cycle, set the widest
// image; they need no clearing after reset. Writing the width or height
// restarts the frame; write configuration only while idle.
module local_maximum_3x3_detector
  import lmd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pix_valid,
  output logic                   pix_stall,
  input  lmd_in_t                pix_data,
  output logic                   res_valid,
  input  logic                   res_stall,
  output lmd_out_t               res_data,
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PEND_W = $clog2(MAX_WIDTH + 2);
  localparam int DEF_W_EFF = (DEF_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_WIDTH;
  localparam int DEF_H_EFF = (DEF_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : DEF_HEIGHT;

  logic [COL_W-1:0]      wid_last;
  logic [ROW_W-1:0]      hgt_last;
  logic [THR_W-1:0]      thr;
  logic [COL_W-1:0]      cfg_wid_last;
  logic [ROW_W-1:0]      cfg_hgt_last;

  logic [COL_W-1:0]      scol;
  logic [ROW_W-1:0]      srow;
  logic [COL_W-1:0]      ocol;
  logic [ROW_W-1:0]      orow;
  logic [PEND_W-1:0]     pending;
  logic                  bubble;

  logic                  a_valid;
  logic                  a_emit;
  logic [PIXEL_BITS-1:0] a_pix;
  logic [COL_W-1:0]      a_col;
  lmd_bound_t            a_bound;
  logic [COL_W-1:0]      a_ocol;
  logic [ROW_W-1:0]      a_orow;
  logic                  a_end;

  logic                  w_valid;
  lmd_bound_t            w_bound;
  logic [COL_W-1:0]      w_ocol;
  logic [ROW_W-1:0]      w_orow;
  logic                  w_end;

  logic [PIXEL_BITS-1:0] rd0;
  logic [PIXEL_BITS-1:0] rd1;
  logic                  win_is_max;

  logic                  ready_c;
  logic                  ready_w;
  logic                  ready_a;
  logic                  adv_a;
  logic                  accept;
  logic                  is_flush;
  logic                  step_pix;
  logic                  step_flush;
  logic                  step_bub;
  logic                  step;
  logic                  step_emit;
  logic                  frame_done;
  logic                  last_flush;
  lmd_bound_t            cur_bound;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_wid_last = '0;
    end else if (32'(cfg_data) > MAX_WIDTH) begin
      cfg_wid_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      cfg_wid_last = COL_W'(32'(cfg_data) - 32'd1);
    end
    if (cfg_data == '0) begin
      cfg_hgt_last = '0;
    end else if (32'(cfg_data) > MAX_HEIGHT) begin
      cfg_hgt_last = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      cfg_hgt_last = ROW_W'(32'(cfg_data) - 32'd1);
    end
  end

  assign ready_c   = !res_valid || !res_stall;
  assign ready_w   = !w_valid || ready_c;
  assign ready_a   = !a_valid || ready_w;
  assign adv_a     = a_valid && ready_w;
  assign pix_stall = !ready_a || bubble;
  assign accept    = pix_valid && !pix_stall;
  assign is_flush  = (pix_data.req_type == REQ_FLUSH);

  assign step_pix   = accept && !is_flush && (pending == '0);
  assign step_flush = accept && is_flush && (pending != '0);
  assign step_bub   = bubble && ready_a;
  assign step       = step_pix || step_flush || step_bub;
  assign frame_done = (srow == hgt_last) && (scol == wid_last);
  assign last_flush = step_flush && (pending == PEND_W'(1));

  always_comb begin
    step_emit = step_flush;
    if (step_pix) begin
      step_emit = (srow > ROW_W'(1)) || ((srow == ROW_W'(1)) && (scol != '0));
    end
  end

  assign cur_bound.top    = (orow == '0);
  assign cur_bound.bottom = (orow == hgt_last);
  assign cur_bound.left   = (ocol == '0);
  assign cur_bound.right  = (ocol == wid_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      wid_last <= COL_W'(DEF_W_EFF - 1);
      hgt_last <= ROW_W'(DEF_H_EFF - 1);
      thr      <= THR_W'(DEF_THRESHOLD);
      scol     <= '0;
      srow     <= '0;
      ocol     <= '0;
      orow     <= '0;
      pending  <= '0;
      bubble   <= 1'b0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          wid_last <= cfg_wid_last;
          scol     <= '0;
          srow     <= '0;
          ocol     <= '0;
          orow     <= '0;
          pending  <= '0;
          bubble   <= 1'b0;
        end
        REG_IMAGE_HEIGHT: begin
          hgt_last <= cfg_hgt_last;
          scol     <= '0;
          srow     <= '0;
          ocol     <= '0;
          orow     <= '0;
          pending  <= '0;
          bubble   <= 1'b0;
        end
        REG_THRESHOLD: begin
          thr <= cfg_data[THR_W-1:0];
        end
        default: begin
        end
      endcase
    end else begin
      if (step) begin
        if (last_flush || (scol == wid_last)) begin
          scol <= '0;
        end else begin
          scol <= scol + COL_W'(1);
        end
      end
      if (step_pix) begin
        if (frame_done) begin
          srow <= '0;
        end else if (scol == wid_last) begin
          srow <= srow + ROW_W'(1);
        end
      end
      if (step_emit) begin
        if (last_flush) begin
          ocol <= '0;
          orow <= '0;
        end else if (ocol == wid_last) begin
          ocol <= '0;
          orow <= orow + ROW_W'(1);
        end else begin
          ocol <= ocol + COL_W'(1);
        end
      end
      if (step_pix && frame_done) begin
        pending <= PEND_W'(wid_last) + ((hgt_last == '0) ? PEND_W'(1) : PEND_W'(2));
      end else if (step_flush) begin
        pending <= pending - PEND_W'(1);
      end
      if (step_pix && frame_done && (hgt_last == '0)) begin
        bubble <= 1'b1;
      end else if (step_bub) begin
        bubble <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      w_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (step) begin
        a_valid <= 1'b1;
      end else if (adv_a) begin
        a_valid <= 1'b0;
      end
      if (adv_a) begin
        w_valid <= a_emit;
      end else if (ready_c) begin
        w_valid <= 1'b0;
      end
      if (ready_c) begin
        res_valid <= w_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      a_emit  <= step_emit;
      a_pix   <= step_pix ? PIXEL_BITS'(pix_data.pixel_value) : '0;
      a_col   <= scol;
      a_bound <= cur_bound;
      a_ocol  <= ocol;
      a_orow  <= orow;
      a_end   <= cur_bound.bottom && cur_bound.right;
    end
    if (adv_a) begin
      w_bound <= a_bound;
      w_ocol  <= a_ocol;
      w_orow  <= a_orow;
      w_end   <= a_end;
    end
    if (ready_c && w_valid) begin
      res_data.is_max    <= win_is_max;
      res_data.col       <= POS_W'(w_ocol);
      res_data.row       <= POS_W'(w_orow);
      res_data.frame_end <= w_end;
    end
  end

  lmd_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS),
    .ADDR_W (COL_W)
  ) u_line0 (
    .clk     (clk),
    .wr_en   (adv_a),
    .wr_addr (a_col),
    .wr_data (a_pix),
    .rd_en   (step),
    .rd_addr (scol),
    .rd_data (rd0)
  );

  lmd_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS),
    .ADDR_W (COL_W)
  ) u_line1 (
    .clk     (clk),
    .wr_en   (adv_a),
    .wr_addr (a_col),
    .wr_data (rd0),
    .rd_en   (step),
    .rd_addr (scol),
    .rd_data (rd1)
  );

  lmd_window #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_window (
    .clk     (clk),
    .shift   (adv_a),
    .top_pix (rd1),
    .mid_pix (rd0),
    .bot_pix (a_pix),
    .bound   (w_bound),
    .thr     (thr),
    .is_max  (win_is_max)
  );

endmodule

FILE: src/lmd_line_ram.sv
// One line store: single write port, registered read port, write-first on a
// same-address collision. Depends on nothing.
module lmd_line_ram #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 8,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

FILE: src/lmd_window.sv
// 3x3 pixel window and the thresholded local-maximum test on its center.
// Depends on lmd_pkg (lmd_bound_t, THR_W).
module lmd_window
  import lmd_pkg::*;
#(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  shift,
  input  logic [PIXEL_BITS-1:0] top_pix,
  input  logic [PIXEL_BITS-1:0] mid_pix,
  input  logic [PIXEL_BITS-1:0] bot_pix,
  input  lmd_bound_t            bound,
  input  logic [THR_W-1:0]      thr,
  output logic                  is_max
);

  localparam int CMP_W = (PIXEL_BITS > THR_W) ? PIXEL_BITS : THR_W;

  logic [PIXEL_BITS-1:0] win [3][3];
  logic [PIXEL_BITS-1:0] new_col [3];
  logic                  row_ok [3];
  logic                  col_ok [3];
  logic                  nb_ok;
  logic                  any_nb;
  logic                  above;

  assign new_col[0] = top_pix;
  assign new_col[1] = mid_pix;
  assign new_col[2] = bot_pix;

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
        win[r][2] <= new_col[r];
      end
    end
  end

  assign row_ok[0] = !bound.top;
  assign row_ok[1] = 1'b1;
  assign row_ok[2] = !bound.bottom;
  assign col_ok[0] = !bound.left;
  assign col_ok[1] = 1'b1;
  assign col_ok[2] = !bound.right;

  assign above = CMP_W'(win[1][1]) > CMP_W'(thr);

  always_comb begin
    nb_ok  = 1'b1;
    any_nb = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 1 && c == 1) && row_ok[r] && col_ok[c]) begin
          any_nb = 1'b1;
          if (win[r][c] > win[1][1]) begin
            nb_ok = 1'b0;
          end
        end
      end
    end
    is_max = nb_ok && (!any_nb || above);
  end

endmodule

FILE: src/lmd_port_checker.sv
// Port-level checks of the local maximum detector, bound to the top level.
// Depends on lmd_pkg (lmd_out_t, POS_W).
module lmd_port_checker
  import lmd_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     pix_stall,
  input logic     res_valid,
  input logic     res_stall,
  input lmd_out_t res_data
);

  // Hold a stalled result transaction.
  a_res_hold : assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  // Drop all results on reset.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result present after reset");

  // Accept input right after reset.
  a_reset_ready : assert property (@(posedge clk)
    rst |=> !pix_stall)
    else $error("input stalled after reset");

  // Advance the column by one between back-to-back results, save at a wrap to 0.
  a_col_step : assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !res_data.frame_end ##1 res_valid && res_data.col != '0)
      |-> res_data.col == POS_W'($past(res_data.col) + POS_W'(1)))
    else $error("result column out of sequence");

endmodule

bind local_maximum_3x3_detector lmd_port_checker u_port_checker (.*);

FILE: tb/local_maximum_3x3_detector_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the 3x3 local maximum detector.
// Depends on lmd_pkg and local_maximum_3x3_detector; an in-bench predictor
// follows the pixel stream and checks every result transaction in order.
module local_maximum_3x3_detector_test;
  import lmd_pkg::*;

  localparam int RING_LEN      = 2 * MAX_WIDTH_DEF + 4;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int SETTLE_CYCLES = 8;

  localparam lmd_out_t LONE_PIXEL_MAX = '{1'b1, '0, '0, 1'b1};

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_mode_t;

  typedef struct {
    row_kind_t             kind;
    cfg_reg_t              reg_sel;
    logic [CFG_DATA_W-1:0] value;
    lmd_in_t               item;
    bit                    typed;
    lmd_out_t              result;
  } directed_row_t;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   pix_valid    = 1'b0;
  logic                   pix_stall;
  lmd_in_t                pix_data     = '0;
  logic                   res_valid;
  logic                   res_stall    = 1'b0;
  lmd_out_t               res_data;
  logic                   cfg_write_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  logic     pix_typed_on  = 1'b0;
  lmd_out_t pix_typed_res = '0;

  logic [7:0]            ring_px [RING_LEN];
  int unsigned           cur_col;
  int unsigned           cur_row;
  int unsigned           flush_left;
  int unsigned           next_out;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  logic [THR_W-1:0]      thr_reg;

  lmd_out_t      maxima_due [$];
  directed_row_t directed_rows [$];

  int          errors     = 0;
  int          cycles     = 0;
  int          burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;

  local_maximum_3x3_detector u_top (
    .clk          (clk),
    .rst          (rst),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .pix_data     (pix_data),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res_data     (res_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic void restart_frame();
    cur_col    = 0;
    cur_row    = 0;
    flush_left = 0;
    next_out   = 0;
  endfunction

  function automatic void apply_config(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
    case (sel)
      REG_IMAGE_WIDTH: begin
        width_reg = value;
        restart_frame();
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = value;
        restart_frame();
      end
      REG_THRESHOLD: begin
        thr_reg = value[THR_W-1:0];
      end
      default: ;
    endcase
  endfunction

  function automatic lmd_out_t judge_next();
    int unsigned w;
    int unsigned h;
    int unsigned k;
    int unsigned r;
    int unsigned c;
    int          nr;
    int          nc;
    logic [7:0]  v;
    logic [7:0]  nb;
    lmd_out_t    res;
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
    k = next_out;
    r = k / w;
    c = k % w;
    v = ring_px[k % RING_LEN];
    res.is_max = 1'b1;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = int'(r) + dr;
        nc = int'(c) + dc;
        if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < int'(h) && nc < int'(w)) begin
          nb = ring_px[(nr * w + nc) % RING_LEN];
          if (!(v >= nb && v > thr_reg)) res.is_max = 1'b0;
        end
      end
    end
    res.col       = c[POS_W-1:0];
    res.row       = r[POS_W-1:0];
    res.frame_end = (k == w * h - 1);
    next_out = k + 1;
    return res;
  endfunction

  function automatic bit predict_item(input lmd_in_t it, output lmd_out_t res);
    int unsigned w;
    int unsigned h;
    int unsigned n;
    bit          got;
    w   = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h   = clamp_dim(height_reg, MAX_HEIGHT_DEF);
    got = 1'b0;
    res = '0;
    if (it.req_type == REQ_FLUSH) begin
      if (flush_left == 0) return 1'b0;
      res = judge_next();
      flush_left--;
      if (flush_left == 0) next_out = 0;
      return 1'b1;
    end
    if (flush_left != 0) return 1'b0;
    if (cur_col >= w || cur_row >= h) restart_frame();
    n = cur_row * w + cur_col;
    ring_px[n % RING_LEN] = it.pixel_value;
    if (n >= w + 1) begin
      res = judge_next();
      got = 1'b1;
    end
    if (n == w * h - 1) begin
      flush_left = w * h - next_out;
      cur_col    = 0;
      cur_row    = 0;
    end else begin
      cur_col++;
      if (cur_col >= w) begin
        cur_col = 0;
        cur_row++;
      end
    end
    return got;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    lmd_out_t want;
    lmd_out_t pred;
    bit       got;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (maxima_due.size() == 0) begin
          errors++;
          $display("%0t: result expected none actual %p", $time, res_data);
        end else begin
          want = maxima_due[0];
          maxima_due.delete(0);
          check_field("is_max", 32'(want.is_max), 32'(res_data.is_max));
          check_field("col", 32'(want.col), 32'(res_data.col));
          check_field("row", 32'(want.row), 32'(res_data.row));
          check_field("frame_end", 32'(want.frame_end), 32'(res_data.frame_end));
        end
      end
      if (cfg_write_en) apply_config(cfg_reg_t'(cfg_index), cfg_data);
      if (pix_valid && !pix_stall) begin
        got = predict_item(pix_data, pred);
        if (got) maxima_due.insert(maxima_due.size(), pix_typed_on ? pix_typed_res : pred);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(40, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  res_stall <= 1'b0;
      STALL_LIGHT: res_stall <= ($urandom_range(0, 7) == 0);
      STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
      default:     res_stall <= (cycles % 5 < 2);
    endcase
  end

  function automatic lmd_in_t make_item(req_type_t req, logic [7:0] px);
    lmd_in_t it;
    it.req_type    = req;
    it.pixel_value = px;
    return it;
  endfunction

  function automatic void add_item(req_type_t req, logic [7:0] px, bit typed = 1'b0,
                                   lmd_out_t result = '0);
    directed_row_t row;
    row.kind    = ROW_ITEM;
    row.reg_sel = REG_THRESHOLD;
    row.value   = '0;
    row.item    = make_item(req, px);
    row.typed   = typed;
    row.result  = result;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void add_cfg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
    directed_row_t row;
    row.kind    = ROW_CFG;
    row.reg_sel = sel;
    row.value   = value;
    row.item    = '0;
    row.typed   = 1'b0;
    row.result  = '0;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      gap = $urandom_range(1, 7);
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_item(lmd_in_t it, bit typed, lmd_out_t res);
    pix_data      <= it;
    pix_typed_on  <= typed;
    pix_typed_res <= res;
    pix_valid     <= 1'b1;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    pace();
  endtask

  task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
    pix_valid <= 1'b0;
    @(posedge clk);
    while (maxima_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= sel;
    cfg_data     <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    return ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 255))
                                       : CFG_DATA_W'($urandom_range(0, 40));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'($urandom_range(7, 16));
      default: return CFG_DATA_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic send_frame(int unsigned w, int unsigned h, bit broken, inout int items);
    int unsigned total;
    int unsigned cut;
    int unsigned pend;
    int unsigned base;
    bit          narrow;
    total  = w * h;
    pend   = (total < w + 1) ? total : w + 1;
    cut    = broken ? $urandom_range(0, total - 1) : total;
    narrow = 1'($urandom_range(0, 1));
    base   = $urandom_range(0, 252);
    for (int unsigned i = 0; i < cut; i++) begin
      if ($urandom_range(0, 31) == 0) send_item(make_item(REQ_FLUSH, 8'($urandom)), 1'b0, '0);
      send_item(make_item(REQ_PIXEL, narrow ? 8'(base + $urandom_range(0, 3))
                                            : 8'($urandom_range(0, 255))), 1'b0, '0);
      items++;
    end
    if (!broken) begin
      for (int unsigned i = 0; i < pend; i++) begin
        if ($urandom_range(0, 15) == 0) send_item(make_item(REQ_PIXEL, 8'($urandom)), 1'b0, '0);
        if (i > 0 && $urandom_range(0, 31) == 0) write_reg(REG_THRESHOLD, pick_threshold());
        send_item(make_item(REQ_FLUSH, 8'($urandom)), 1'b0, '0);
        items++;
      end
      if ($urandom_range(0, 7) == 0) send_item(make_item(REQ_FLUSH, 8'($urandom)), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    int          items;
    int          frames;
    int unsigned w;
    int unsigned h;
    bit          broken;
    foreach (ring_px[i]) ring_px[i] = '0;
    width_reg  = CFG_DATA_W'(DEF_WIDTH);
    height_reg = CFG_DATA_W'(DEF_HEIGHT);
    thr_reg    = THR_W'(DEF_THRESHOLD);
    restart_frame();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    add_item(REQ_PIXEL, 8'h00);
    add_item(REQ_PIXEL, 8'hFF);
    add_item(REQ_PIXEL, 8'h80);
    add_item(REQ_FLUSH, 8'h00);
    add_cfg(REG_IMAGE_WIDTH, 0);
    add_cfg(REG_IMAGE_HEIGHT, 0);
    add_item(REQ_PIXEL, 8'h00);
    add_item(REQ_PIXEL, 8'h4D);
    add_item(REQ_FLUSH, 8'h00, 1'b1, LONE_PIXEL_MAX);
    add_item(REQ_FLUSH, 8'hFF);
    add_cfg(REG_THRESHOLD, 255);
    add_item(REQ_PIXEL, 8'hFF);
    add_item(REQ_FLUSH, 8'h00, 1'b1, LONE_PIXEL_MAX);
    add_cfg(REG_THRESHOLD, 9);
    add_cfg(REG_IMAGE_WIDTH, 3);
    add_cfg(REG_IMAGE_HEIGHT, 2);
    add_item(REQ_PIXEL, 8'd10);
    add_item(REQ_PIXEL, 8'd255);
    add_item(REQ_PIXEL, 8'd0);
    add_item(REQ_PIXEL, 8'd255);
    add_item(REQ_PIXEL, 8'd9);
    add_item(REQ_PIXEL, 8'd0);
    add_item(REQ_FLUSH, 8'h00);
    add_item(REQ_FLUSH, 8'h00);
    add_item(REQ_PIXEL, 8'hAA);
    add_cfg(REG_THRESHOLD, 0);
    add_item(REQ_FLUSH, 8'h00);
    add_item(REQ_FLUSH, 8'h00);
    add_cfg(REG_IMAGE_WIDTH, 2);
    add_cfg(REG_IMAGE_HEIGHT, 2);
    add_item(REQ_PIXEL, 8'd1);
    add_item(REQ_PIXEL, 8'd2);
    add_item(REQ_PIXEL, 8'd3);
    add_item(REQ_PIXEL, 8'd4);
    add_cfg(REG_IMAGE_WIDTH, 2);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
      else
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
    end

    items = 0;
    write_reg(REG_THRESHOLD, pick_threshold());
    write_reg(REG_IMAGE_WIDTH, 2047);
    write_reg(REG_IMAGE_HEIGHT, 1);
    send_frame(MAX_WIDTH_DEF, 1, 1'b0, items);
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, 2047);
    send_frame(1, MAX_HEIGHT_DEF, 1'b0, items);

    items  = 0;
    broken = 1'b0;
    while (items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) write_reg(REG_THRESHOLD, pick_threshold());
      if (broken || $urandom_range(0, 2) != 0) write_reg(REG_IMAGE_WIDTH, pick_dim());
      if ($urandom_range(0, 2) != 0) write_reg(REG_IMAGE_HEIGHT, pick_dim());
      w      = clamp_dim(width_reg, MAX_WIDTH_DEF);
      h      = clamp_dim(height_reg, MAX_HEIGHT_DEF);
      frames = $urandom_range(1, 3);
      broken = 1'b0;
      repeat (frames) begin
        if (!broken) begin
          broken = ($urandom_range(0, 9) == 0);
          send_frame(w, h, broken, items);
        end
      end
    end

    pix_valid <= 1'b0;
    @(posedge clk);
    while (maxima_due.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
